FILE: rtl/core/tps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle plane slice package
// Shared widths, register codes, pipeline payload types and helpers.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int COORD_W    = 32;
   localparam int TOL_W      = 16;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int LANES      = 4;
   localparam int DIV_STEPS  = COORD_W;
   localparam int REQ_DATA_W = 9 * COORD_W;
   localparam int RSP_DATA_W = LANES * COORD_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [1:0]                vidx_type;
   typedef logic [0:0]                reg_idx_type;

   localparam reg_idx_type REG_PLANE_HEIGHT = 1'b0;
   localparam reg_idx_type REG_EQUAL_TOL    = 1'b1;

   // case decision for one triangle
   typedef struct packed {
      logic                 cut;
      logic     [1:0]       vtx;
      vidx_type [1:0]       sel;
      vidx_type [1:0]       ci;
      vidx_type [1:0]       cj;
   } class_type;

   // one segment end point: vertex copy or base plus/minus quotient
   typedef struct packed {
      coord_type base_x;
      coord_type base_y;
      logic      dir_x;
      logic      dir_y;
      logic      vtx;
   } end_type;

   typedef struct packed {
      logic              cut;
      end_type [1:0]     ends;
   } side_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic [COORD_W-1:0] rem;
      logic [COORD_W-1:0] low;
      logic [COORD_W-1:0] quo;
      logic [COORD_W-1:0] den;
   } div_lane_type;

   function automatic logic [COORD_W-1:0] abs_diff(coord_type a, coord_type b);
      logic signed [COORD_W:0] d;
      logic        [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

   // one quotient bit: shift in the next dividend bit, subtract when it fits
   function automatic div_lane_type div_step(div_lane_type a);
      logic [COORD_W:0] t;
      logic [COORD_W:0] d;
      div_lane_type     r;
      t     = {a.rem, a.low[COORD_W-1]};
      d     = t - {1'b0, a.den};
      r     = a;
      r.low = {a.low[COORD_W-2:0], 1'b0};
      if (t >= {1'b0, a.den}) begin
         r.rem = d[COORD_W-1:0];
         r.quo = {a.quo[COORD_W-2:0], 1'b1};
      end else begin
         r.rem = t[COORD_W-1:0];
         r.quo = {a.quo[COORD_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle plane slice front end
// Input register, case classification, edge operands and products.
// Four register stages, all advancing together on adv.
// ----------------------------------------------------------------------------
module tps_front (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        src_valid,
   input  logic [tps_pkg::REQ_DATA_W-1:0]              src_data,
   input  tps_pkg::coord_type                          plane_height,
   input  logic [tps_pkg::TOL_W-1:0]                   equal_tolerance,
   output logic                                        dst_valid,
   output tps_pkg::div_lane_type [tps_pkg::LANES-1:0]  dst_lane,
   output tps_pkg::side_type                           dst_side
);
   import tps_pkg::*;

   // stage A: captured triangle
   coord_type a_x_ff [3];
   coord_type a_y_ff [3];
   coord_type a_z_ff [3];
   logic      a_valid_ff;

   // stage B: classified triangle
   coord_type b_x_ff [3];
   coord_type b_y_ff [3];
   coord_type b_z_ff [3];
   class_type b_class_ff;
   class_type b_class_in;
   logic      b_valid_ff;

   // stage C: edge operands
   logic [COORD_W-1:0] c_num_ff [2];
   logic [COORD_W-1:0] c_den_ff [2];
   logic [COORD_W-1:0] c_dc_ff  [LANES];
   logic [COORD_W-1:0] c_num_in [2];
   logic [COORD_W-1:0] c_den_in [2];
   logic [COORD_W-1:0] c_dc_in  [LANES];
   side_type           c_side_ff;
   side_type           c_side_in;
   logic               c_valid_ff;

   // stage D: products loaded into divider lanes
   div_lane_type [LANES-1:0] d_lane_ff;
   div_lane_type [LANES-1:0] d_lane_in;
   side_type                 d_side_ff;
   logic                     d_valid_ff;

   logic                ab [3];
   logic                bl [3];
   logic                on [3];
   logic signed [COORD_W:0] dz [3];
   logic [COORD_W:0]    mag [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= src_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            a_x_ff[k] <= src_data[3*k*COORD_W             +: COORD_W];
            a_y_ff[k] <= src_data[3*k*COORD_W + COORD_W   +: COORD_W];
            a_z_ff[k] <= src_data[3*k*COORD_W + 2*COORD_W +: COORD_W];
            b_x_ff[k] <= a_x_ff[k];
            b_y_ff[k] <= a_y_ff[k];
            b_z_ff[k] <= a_z_ff[k];
         end
         b_class_ff <= b_class_in;
         for (int e = 0; e < 2; e++) begin
            c_num_ff[e] <= c_num_in[e];
            c_den_ff[e] <= c_den_in[e];
         end
         for (int l = 0; l < LANES; l++) begin
            c_dc_ff[l] <= c_dc_in[l];
         end
         c_side_ff <= c_side_in;
         d_lane_ff <= d_lane_in;
         d_side_ff <= c_side_ff;
      end
   end

   // side of the plane for each vertex, exact 33-bit difference
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dz[k]  = {a_z_ff[k][COORD_W-1], a_z_ff[k]}
                - {plane_height[COORD_W-1], plane_height};
         mag[k] = dz[k][COORD_W] ? -dz[k] : dz[k];
         bl[k]  = dz[k][COORD_W];
         ab[k]  = !dz[k][COORD_W] && (dz[k] != '0);
         on[k]  = mag[k] <= (COORD_W+1)'(equal_tolerance);
      end
   end

   function automatic logic same_side(logic ab_a, logic ab_b, logic bl_a, logic bl_b);
      return (ab_a && ab_b) || (bl_a && bl_b);
   endfunction

   always_comb begin
      b_class_in     = '0;
      b_class_in.cut = 1'b1;
      if ((ab[0] && ab[1] && ab[2]) || (bl[0] && bl[1] && bl[2])) begin
         b_class_in.cut = 1'b0;
      end else if (on[0]) begin
         if (on[1]) begin
            if (on[2]) begin
               b_class_in.cut = 1'b0;
            end else begin
               b_class_in.vtx    = 2'b11;
               b_class_in.sel[0] = 2'd0;
               b_class_in.sel[1] = 2'd1;
            end
         end else if (on[2]) begin
            b_class_in.vtx    = 2'b11;
            b_class_in.sel[0] = 2'd0;
            b_class_in.sel[1] = 2'd2;
         end else if (same_side(ab[1], ab[2], bl[1], bl[2])) begin
            b_class_in.cut = 1'b0;
         end else begin
            b_class_in.vtx    = 2'b01;
            b_class_in.sel[0] = 2'd0;
            b_class_in.ci[1]  = 2'd1;
            b_class_in.cj[1]  = 2'd2;
         end
      end else if (on[1]) begin
         if (on[2]) begin
            b_class_in.vtx    = 2'b11;
            b_class_in.sel[0] = 2'd1;
            b_class_in.sel[1] = 2'd2;
         end else if (same_side(ab[0], ab[2], bl[0], bl[2])) begin
            b_class_in.cut = 1'b0;
         end else begin
            b_class_in.vtx    = 2'b01;
            b_class_in.sel[0] = 2'd1;
            b_class_in.ci[1]  = 2'd0;
            b_class_in.cj[1]  = 2'd2;
         end
      end else if (on[2]) begin
         if (same_side(ab[0], ab[1], bl[0], bl[1])) begin
            b_class_in.cut = 1'b0;
         end else begin
            b_class_in.vtx    = 2'b01;
            b_class_in.sel[0] = 2'd2;
            b_class_in.ci[1]  = 2'd0;
            b_class_in.cj[1]  = 2'd1;
         end
      end else if (same_side(ab[0], ab[1], bl[0], bl[1])) begin
         b_class_in.ci[0] = 2'd2;
         b_class_in.cj[0] = 2'd0;
         b_class_in.ci[1] = 2'd2;
         b_class_in.cj[1] = 2'd1;
      end else if (same_side(ab[0], ab[2], bl[0], bl[2])) begin
         b_class_in.ci[0] = 2'd1;
         b_class_in.cj[0] = 2'd0;
         b_class_in.ci[1] = 2'd1;
         b_class_in.cj[1] = 2'd2;
      end else if (same_side(ab[1], ab[2], bl[1], bl[2])) begin
         b_class_in.ci[0] = 2'd0;
         b_class_in.cj[0] = 2'd1;
         b_class_in.ci[1] = 2'd0;
         b_class_in.cj[1] = 2'd2;
      end else begin
         b_class_in.cut = 1'b0;
      end
   end

   // edge operands; a missing cut forces zero vertex end points
   always_comb begin
      c_side_in     = '0;
      c_side_in.cut = b_class_ff.cut;
      for (int e = 0; e < 2; e++) begin
         c_den_in[e]       = abs_diff(b_z_ff[b_class_ff.cj[e]], b_z_ff[b_class_ff.ci[e]]);
         c_num_in[e]       = abs_diff(plane_height, b_z_ff[b_class_ff.ci[e]]);
         c_dc_in[2*e]      = abs_diff(b_x_ff[b_class_ff.cj[e]], b_x_ff[b_class_ff.ci[e]]);
         c_dc_in[2*e+1]    = abs_diff(b_y_ff[b_class_ff.cj[e]], b_y_ff[b_class_ff.ci[e]]);
         if (!b_class_ff.cut) begin
            c_side_in.ends[e].vtx = 1'b1;
         end else if (b_class_ff.vtx[e]) begin
            c_side_in.ends[e].vtx    = 1'b1;
            c_side_in.ends[e].base_x = b_x_ff[b_class_ff.sel[e]];
            c_side_in.ends[e].base_y = b_y_ff[b_class_ff.sel[e]];
         end else begin
            c_side_in.ends[e].base_x = b_x_ff[b_class_ff.ci[e]];
            c_side_in.ends[e].base_y = b_y_ff[b_class_ff.ci[e]];
            c_side_in.ends[e].dir_x  = b_x_ff[b_class_ff.cj[e]] >= b_x_ff[b_class_ff.ci[e]];
            c_side_in.ends[e].dir_y  = b_y_ff[b_class_ff.cj[e]] >= b_y_ff[b_class_ff.ci[e]];
         end
      end
   end

   // product num * dc; its high half seeds the remainder
   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int l = 0; l < LANES; l++) begin
         prod             = PROD_W'(c_num_ff[l/2]) * PROD_W'(c_dc_ff[l]);
         d_lane_in[l].rem = prod[PROD_W-1:COORD_W];
         d_lane_in[l].low = prod[COORD_W-1:0];
         d_lane_in[l].quo = '0;
         d_lane_in[l].den = c_den_ff[l/2];
      end
   end

   assign dst_valid = d_valid_ff;
   assign dst_lane  = d_lane_ff;
   assign dst_side  = d_side_ff;

endmodule
`default_nettype wire

FILE: rtl/core/tps_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle plane slice divider pipeline
// Restoring division, one quotient bit per stage, four lanes side by side.
// ----------------------------------------------------------------------------
module tps_div_pipe (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        src_valid,
   input  tps_pkg::div_lane_type [tps_pkg::LANES-1:0]  src_lane,
   input  tps_pkg::side_type                           src_side,
   output logic                                        dst_valid,
   output tps_pkg::div_lane_type [tps_pkg::LANES-1:0]  dst_lane,
   output tps_pkg::side_type                           dst_side
);
   import tps_pkg::*;

   div_lane_type [LANES-1:0] lane_ff  [DIV_STEPS];
   div_lane_type [LANES-1:0] lane_in  [DIV_STEPS];
   side_type                 side_ff  [DIV_STEPS];
   side_type                 side_in  [DIV_STEPS];
   logic                     valid_ff [DIV_STEPS];
   logic                     valid_in [DIV_STEPS];

   always_comb begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            side_in[s]  = src_side;
            valid_in[s] = src_valid;
            for (int l = 0; l < LANES; l++) begin
               lane_in[s][l] = div_step(src_lane[l]);
            end
         end else begin
            side_in[s]  = side_ff[s-1];
            valid_in[s] = valid_ff[s-1];
            for (int l = 0; l < LANES; l++) begin
               lane_in[s][l] = div_step(lane_ff[s-1][l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            lane_ff[s] <= lane_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign dst_valid = valid_ff[DIV_STEPS-1];
   assign dst_lane  = lane_ff[DIV_STEPS-1];
   assign dst_side  = side_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/core/triangle_plane_slice.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a request accepted at one clock edge shows on rsp_tvalid after passing
//   4 front stages, 32 divider stages one quotient bit each, and the output register.
// Throughput: one triangle per cycle; every stage advances together when the
//   output register is empty or being taken.
// Reset: synchronous; clears all valid bits, plane_height and equal_tolerance.
// ----------------------------------------------------------------------------
// Triangle plane slice
// Cuts a triangle with the plane z = plane_height and returns the xy segment.
// ----------------------------------------------------------------------------
module triangle_plane_slice (
   input  logic                               clock,
   input  logic                               reset,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // third_x, third_y, third_z
   input  logic [tps_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_x, start_y, end_x, end_y
   output logic [tps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // cut
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import tps_pkg::*;

   coord_type          plane_height_ff;
   logic [TOL_W-1:0]   equal_tolerance_ff;
   reg_idx_type        reg_idx;
   logic               csr_write;

   logic                     adv;
   logic                     front_valid;
   div_lane_type [LANES-1:0] front_lane;
   side_type                 front_side;
   logic                     div_valid;
   div_lane_type [LANES-1:0] div_lane;
   side_type                 div_side;

   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_in;
   logic                     rsp_user_ff;
   logic                     rsp_valid_ff;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_height_ff    <= '0;
         equal_tolerance_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_PLANE_HEIGHT: plane_height_ff    <= csr_pwdata;
            REG_EQUAL_TOL:    equal_tolerance_ff <= csr_pwdata[TOL_W-1:0];
            default:          plane_height_ff    <= plane_height_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PLANE_HEIGHT: csr_prdata = plane_height_ff;
         REG_EQUAL_TOL:    csr_prdata = CSR_DATA_W'(equal_tolerance_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // advance the whole pipe whenever the output register can take a result
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   tps_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .src_valid       (req_tvalid),
      .src_data        (req_tdata),
      .plane_height    (plane_height_ff),
      .equal_tolerance (equal_tolerance_ff),
      .dst_valid       (front_valid),
      .dst_lane        (front_lane),
      .dst_side        (front_side)
   );

   tps_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .src_valid (front_valid),
      .src_lane  (front_lane),
      .src_side  (front_side),
      .dst_valid (div_valid),
      .dst_lane  (div_lane),
      .dst_side  (div_side)
   );

   // apply the quotient as offset from the edge start, or pass the vertex
   always_comb begin
      coord_type base;
      logic      dir;
      end_type   pt;
      for (int l = 0; l < LANES; l++) begin
         pt   = div_side.ends[l/2];
         base = (l % 2 == 1) ? pt.base_y : pt.base_x;
         dir  = (l % 2 == 1) ? pt.dir_y  : pt.dir_x;
         if (pt.vtx) begin
            rsp_data_in[l*COORD_W +: COORD_W] = base;
         end else if (dir) begin
            rsp_data_in[l*COORD_W +: COORD_W] = base + div_lane[l].quo;
         end else begin
            rsp_data_in[l*COORD_W +: COORD_W] = base - div_lane[l].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= div_side.cut;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_reset_empties : assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_no_cut_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff == '0))
      else $error("end points not zero without a cut");

   a_start_rem : assert property (@(posedge clock) disable iff (reset)
      (div_valid && !div_side.ends[0].vtx) |->
      ((div_lane[0].rem < div_lane[0].den) && (div_lane[1].rem < div_lane[1].den)))
      else $error("start crossing remainder out of range");

   a_end_rem : assert property (@(posedge clock) disable iff (reset)
      (div_valid && !div_side.ends[1].vtx) |->
      ((div_lane[2].rem < div_lane[2].den) && (div_lane[3].rem < div_lane[3].den)))
      else $error("end crossing remainder out of range");

endmodule
`default_nettype wire

FILE: tb/tps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane slice checker
// Watches the request and response streams and the register port, computes
// the expected cut segment for every accepted triangle and compares results.
// ----------------------------------------------------------------------------
module tps_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [tps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending
);
   import tps_pkg::*;

   typedef struct {
      logic      cut;
      coord_type sx, sy, ex, ey;
   } segment_type;

   segment_type     segment_q[$];
   logic signed [63:0] height;
   logic [63:0]     tol;

   function automatic logic [63:0] mag(logic signed [63:0] a, logic signed [63:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // plane crossing of coordinate c on edge i -> j
   function automatic coord_type crossing(logic signed [63:0] ci, logic signed [63:0] cj,
                                          logic signed [63:0] zi, logic signed [63:0] zj,
                                          logic signed [63:0] zp);
      logic [63:0]  den, num, dc, off;
      logic [127:0] prod;
      den = mag(zj, zi);
      num = mag(zp, zi);
      dc  = mag(cj, ci);
      if (den == 0) return ci[31:0];
      prod = {64'd0, num} * {64'd0, dc};
      off  = prod / {64'd0, den};
      return (cj >= ci) ? ci[31:0] + off[31:0] : ci[31:0] - off[31:0];
   endfunction

   function automatic segment_type slice(logic [REQ_DATA_W-1:0] d);
      logic signed [63:0] x[3], y[3], z[3];
      logic ab[3], bl[3], on[3];
      int s0, s1, ci0, cj0, ci1, cj1;
      logic cut;
      segment_type r;
      s0 = -1; s1 = -1; ci0 = 0; cj0 = 0; ci1 = 0; cj1 = 0; cut = 1;
      for (int k = 0; k < 3; k++) begin
         x[k] = $signed(d[(3*k)*32 +: 32]);
         y[k] = $signed(d[(3*k+1)*32 +: 32]);
         z[k] = $signed(d[(3*k+2)*32 +: 32]);
         ab[k] = z[k] > height;
         bl[k] = z[k] < height;
         on[k] = mag(z[k], height) <= tol;
      end
      if ((ab[0] && ab[1] && ab[2]) || (bl[0] && bl[1] && bl[2])) cut = 0;
      else if (on[0]) begin
         if (on[1]) begin
            if (on[2]) cut = 0;
            else begin s0 = 0; s1 = 1; end
         end else if (on[2]) begin
            s0 = 0; s1 = 2;
         end else if ((ab[1] && ab[2]) || (bl[1] && bl[2])) cut = 0;
         else begin s0 = 0; ci1 = 1; cj1 = 2; end
      end else if (on[1]) begin
         if (on[2]) begin s0 = 1; s1 = 2; end
         else if ((ab[0] && ab[2]) || (bl[0] && bl[2])) cut = 0;
         else begin s0 = 1; ci1 = 0; cj1 = 2; end
      end else if (on[2]) begin
         if ((ab[0] && ab[1]) || (bl[0] && bl[1])) cut = 0;
         else begin s0 = 2; ci1 = 0; cj1 = 1; end
      end else if ((ab[0] && ab[1]) || (bl[0] && bl[1])) begin
         ci0 = 2; cj0 = 0; ci1 = 2; cj1 = 1;
      end else if ((ab[0] && ab[2]) || (bl[0] && bl[2])) begin
         ci0 = 1; cj0 = 0; ci1 = 1; cj1 = 2;
      end else if ((ab[1] && ab[2]) || (bl[1] && bl[2])) begin
         ci0 = 0; cj0 = 1; ci1 = 0; cj1 = 2;
      end else cut = 0;
      r.cut = cut;
      r.sx = 0; r.sy = 0; r.ex = 0; r.ey = 0;
      if (!cut) return r;
      if (s0 >= 0) begin
         r.sx = x[s0][31:0]; r.sy = y[s0][31:0];
      end else begin
         r.sx = crossing(x[ci0], x[cj0], z[ci0], z[cj0], height);
         r.sy = crossing(y[ci0], y[cj0], z[ci0], z[cj0], height);
      end
      if (s1 >= 0) begin
         r.ex = x[s1][31:0]; r.ey = y[s1][31:0];
      end else begin
         r.ex = crossing(x[ci1], x[cj1], z[ci1], z[cj1], height);
         r.ey = crossing(y[ci1], y[cj1], z[ci1], z[cj1], height);
      end
      return r;
   endfunction

   task automatic compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      segment_type w;
      if (reset) begin
         height     <= 0;
         tol        <= 0;
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_EQUAL_TOL) tol <= {48'd0, csr_pwdata[15:0]};
            else height <= $signed(csr_pwdata);
         end
         if (req_tvalid && req_tready) segment_q = {segment_q, slice(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            if (segment_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response expected none actual %h", $time,
                        rsp_tdata);
            end else begin
               w = segment_q.pop_front();
               compare("cut", {31'd0, w.cut}, {31'd0, rsp_tuser});
               compare("start_x", w.sx, rsp_tdata[31:0]);
               compare("start_y", w.sy, rsp_tdata[63:32]);
               compare("end_x", w.ex, rsp_tdata[95:64]);
               compare("end_y", w.ey, rsp_tdata[127:96]);
            end
         end
      end
      pending = segment_q.size();
   end
endmodule

FILE: tb/tb_triangle_plane_slice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane slice testbench
// Streams directed and random triangles across several plane and tolerance
// settings with random stalls on both sides; the checker judges responses.
// ----------------------------------------------------------------------------
module tb_triangle_plane_slice;
   import tps_pkg::*;

   logic                  clock, reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid, req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser, rsp_tvalid, rsp_tready;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic                  csr_pready;
   int                    fail_count, pending;
   logic signed [31:0]    cur_height;
   logic [15:0]           cur_tol;

   triangle_plane_slice DUT (.*);

   tps_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("triangle_plane_slice test failed");
      $finish;
   end

   // response side stalls
   initial begin
      int gap;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
               rsp_tready <= 0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1;
      end
   end

   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // drop the request and wait until every response is back
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(logic signed [31:0] h, logic [15:0] t);
      drain();
      cur_height = h;
      cur_tol    = t;
      csr_write(REG_PLANE_HEIGHT, h);
      csr_write(REG_EQUAL_TOL, {16'd0, t});
   endtask

   task automatic send(logic [REQ_DATA_W-1:0] d, bit idle);
      int gap;
      gap = idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand32();
      return $urandom();
   endfunction

   // z near the plane: on, just off, or far
   function automatic logic [31:0] pick_z();
      logic signed [63:0] v;
      case ($urandom_range(0, 4))
         0: v = cur_height;
         1: v = cur_height + $signed({1'b0, $urandom_range(0, cur_tol)});
         2: v = cur_height - $signed({1'b0, $urandom_range(0, cur_tol)});
         3: v = cur_height + $signed(64'($signed(rand32())));
         default: v = cur_height + $signed(64'($signed(32'($urandom_range(0, 65535))
                                               - 32'sd32768)));
      endcase
      if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
      if (v < -64'sh80000000) v = -64'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [REQ_DATA_W-1:0] tri_of(logic [31:0] a[9]);
      logic [REQ_DATA_W-1:0] d;
      for (int k = 0; k < 9; k++) d[k*32 +: 32] = a[k];
      return d;
   endfunction

   initial begin
      logic [31:0] v[9];
      logic [31:0] zs[9];
      reset = 1; req_tvalid = 0; req_tdata = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      cur_height = 0; cur_tol = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: each case class at plane zero and tolerance zero, then extreme planes with wide tolerance
      configure(0, 0);
      zs = '{32'h10000, 32'h20000, 32'h30000,     // all above
             32'hFFFF0000, 32'hFFFE0000, 32'h80000000, // all below
             0, 0, 0};                             // flat face
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 9; k++) v[k] = rand32();
         v[2] = zs[3*c]; v[5] = zs[3*c+1]; v[8] = zs[3*c+2];
         send(tri_of(v), 0);
      end
      for (int c = 0; c < 18; c++) begin
         for (int k = 0; k < 9; k++) v[k] = (c < 4) ? ((c[0]) ? 32'h80000000
                                                               : 32'h7FFFFFFF) : rand32();
         v[2] = (c % 3 == 0) ? 0 : ((c % 2) ? 32'h7FFFFFFF : 32'h80000000);
         v[5] = (c % 3 == 1) ? 0 : ((c % 4 < 2) ? 32'h80000000 : 32'h10000);
         v[8] = (c % 3 == 2) ? 0 : ((c % 5 < 2) ? 32'h7FFFFFFF : 32'hFFFF0000);
         send(tri_of(v), 0);
      end
      configure(32'h7FFFFFFF, 16'hFFFF);
      v = '{32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            5, 6, 32'h7FFF0000};
      send(tri_of(v), 0);
      configure(32'h80000000, 16'hFFFF);
      v = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 2, 32'h80000000, 3, 4,
            32'h80008000};
      send(tri_of(v), 0);

      // random phases over several settings
      for (int p = 0; p < 9; p++) begin
         case (p)
            0: configure(0, 0);
            1: configure(32'h7FFFFFFF, 0);
            2: configure(32'h80000000, 16'hFFFF);
            3: configure(0, 16'hFFFF);
            default: configure(rand32(), 16'($urandom_range(0, 65535)));
         endcase
         for (int n = 0; n < 100; n++) begin
            for (int k = 0; k < 9; k++) v[k] = (k % 3 == 2) ? pick_z() : rand32();
            if (n == 50) drain();
            send(tri_of(v), $urandom_range(0, 2) != 0 && (n / 25) % 2 == 0);
         end
      end
      drain();
      if (fail_count == 0)
         $display("triangle_plane_slice test passed");
      else
         $display("triangle_plane_slice test failed");
      $finish;
   end
endmodule

FILE: files.f
rtl/core/tps_pkg.sv
rtl/core/tps_front.sv
rtl/core/tps_div_pipe.sv
rtl/core/triangle_plane_slice.sv
tb/tps_checker.sv
tb/tb_triangle_plane_slice.sv
